FILE: design/iois_pkg.sv
// Package with the shared constants, request codes and cell control type of the integer set.
`default_nettype none
package iois_pkg;

  // Default number of cells, one member per cell.
  localparam int CAPACITY_DEF = 16;

  // Field widths of the request and response words.
  localparam int MODE_W  = 2;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  // Request kinds.
  localparam logic [MODE_W-1:0] MODE_ADD      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CONTAINS = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd3;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic add;     // store the value in the first free cell
    logic remove;  // shift down every cell at or after the matching one
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: design/iois_if.sv
// Request and response channel interfaces of the integer set.
`default_nettype none
interface iois_req_if;
  logic                                valid;
  logic                                ready;
  logic        [iois_pkg::MODE_W-1:0]  mode;
  logic signed [iois_pkg::VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface iois_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic                         full_refused;
  logic [iois_pkg::COUNT_W-1:0] member_count;

  modport source (output valid, output ok, output full_refused, output member_count,
                  input ready);
  modport sink   (input valid, input ok, input full_refused, input member_count,
                  output ready);
endinterface
`default_nettype wire

FILE: design/iois_cell.sv
// One storage cell of the set: holds one member, compares it and shifts it down on removal.
`default_nettype none
module iois_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 5
) (
  input  wire                                 clk,
  input  wire logic [iois_pkg::VALUE_W-1:0]   value,
  input  wire logic [CW-1:0]                  count,
  input  wire iois_pkg::cell_ctrl_t           ctrl,
  input  wire logic [iois_pkg::VALUE_W-1:0]   next_entry,
  input  wire logic                           hit_in,
  output logic                                hit_out,
  output logic [iois_pkg::VALUE_W-1:0]        entry
);

  logic occupied;
  logic is_tail;

  // The cell holds a member when its place lies below the count.
  always_comb begin
    occupied = CW'(INDEX) < count;
    is_tail  = CW'(INDEX) == count;
    hit_out  = hit_in | (occupied & (entry == value));
  end

  // A new member lands in the first free cell; on removal every cell at or after the
  // match takes its upper neighbour's word.
  always_ff @(posedge clk) begin
    if (ctrl.add && is_tail) begin
      entry <= value;
    end else if (ctrl.remove && hit_out) begin
      entry <= next_entry;
    end
  end

endmodule
`default_nettype wire

FILE: design/insertion_ordered_int_set_core.sv
// Top level of the insertion-ordered integer set: a row of cells and the response register.
//
// The set keeps up to CAPACITY distinct 32-bit words, oldest first, one per cell. For each
// request (add, remove, contains, clear) all cells compare the value at once, a hit signal
// ripples along the row, and on removal every later cell takes its neighbour's word in
// that same cycle. The response word appears in the cycle after the request is taken and
// a new request is taken in every cycle in which the response register is empty or being
// emptied, so the block sustains one request per clock. An add of an absent value to a
// full set is refused and flagged. There is no clearing pass after reset; only the member
// count and the response valid flag are reset.
`default_nettype none
module insertion_ordered_int_set_core #(
  parameter int CAPACITY = iois_pkg::CAPACITY_DEF
) (
  input  wire clk,
  input  wire rst,
  iois_req_if.sink   req,
  iois_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]                  count;
  logic [CW-1:0]                  count_next;
  logic [CAPACITY:0]              hit;
  logic [iois_pkg::VALUE_W-1:0]   entries [CAPACITY];
  iois_pkg::cell_ctrl_t           ctrl;
  logic                           take;
  logic                           found;
  logic                           full;
  logic                           ok_next;
  logic                           refused_next;

  // A request is taken whenever the response register can accept its word.
  assign req.ready = !rsp.valid || rsp.ready;
  assign take      = req.valid && req.ready;

  assign hit[0] = 1'b0;
  assign found  = hit[CAPACITY];
  assign full   = count == CW'(CAPACITY);

  // Decode the request and work out the new count and flags.
  always_comb begin
    ctrl         = '0;
    count_next   = count;
    ok_next      = 1'b0;
    refused_next = 1'b0;
    unique case (req.mode)
      iois_pkg::MODE_ADD: begin
        if (!found && !full) begin
          ctrl.add   = take;
          count_next = count + CW'(1);
          ok_next    = 1'b1;
        end
        refused_next = !found && full;
      end
      iois_pkg::MODE_REMOVE: begin
        ctrl.remove = take;
        if (found) begin
          count_next = count - CW'(1);
          ok_next    = 1'b1;
        end
      end
      iois_pkg::MODE_CONTAINS: begin
        ok_next = found;
      end
      iois_pkg::MODE_CLEAR: begin
        count_next = '0;
        ok_next    = 1'b1;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // The row of cells, each handing its word and the hit signal to its neighbour.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [iois_pkg::VALUE_W-1:0] upper;
    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid
      assign upper = entries[i+1];
    end
    iois_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk        (clk),
      .value      (req.value),
      .count      (count),
      .ctrl       (ctrl),
      .next_entry (upper),
      .hit_in     (hit[i]),
      .hit_out    (hit[i+1]),
      .entry      (entries[i])
    );
  end

  // Member count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (take) begin
      count <= count_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.ok           <= ok_next;
      rsp.full_refused <= refused_next;
      rsp.member_count <= iois_pkg::COUNT_W'(count_next);
    end
  end

endmodule
`default_nettype wire

FILE: verif/insertion_ordered_int_set_core_tb.sv
// Self-checking testbench of the insertion-ordered integer set, with scoreboard and drivers.
`default_nettype none
module insertion_ordered_int_set_core_tb;

  localparam int SET_CAP = iois_pkg::CAPACITY_DEF;
  localparam logic [iois_pkg::VALUE_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [iois_pkg::VALUE_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [iois_pkg::VALUE_W-1:0] WORD_ALL = 32'hFFFF_FFFF;

  // One expected response word.
  typedef struct packed {
    logic                         ok;
    logic                         full_refused;
    logic [iois_pkg::COUNT_W-1:0] member_count;
  } set_reply_t;

  // Shadow copy of the set: it is updated for each accepted request and queues the reply due.
  class int_set_tracker;
    logic [iois_pkg::VALUE_W-1:0] members [SET_CAP];
    int unsigned                  n_members;
    set_reply_t                   replies_due [$];
    int unsigned                  mismatches;

    function void note_request(logic [iois_pkg::MODE_W-1:0] mode,
                               logic [iois_pkg::VALUE_W-1:0] value);
      int         hit;
      set_reply_t r;
      hit = -1;
      r   = '0;
      // The value is compared as a plain 32-bit pattern with every live member.
      for (int i = 0; i < n_members; i++) begin
        if (hit < 0 && members[i] == value) hit = i;
      end
      case (mode)
        iois_pkg::MODE_ADD: begin
          if (hit < 0) begin
            if (n_members < SET_CAP) begin
              members[n_members] = value;
              n_members++;
              r.ok = 1'b1;
            end else begin
              r.full_refused = 1'b1;
            end
          end
        end
        iois_pkg::MODE_REMOVE: begin
          if (hit >= 0) begin
            for (int j = hit; j + 1 < n_members; j++) members[j] = members[j + 1];
            n_members--;
            r.ok = 1'b1;
          end
        end
        iois_pkg::MODE_CONTAINS: r.ok = (hit >= 0);
        iois_pkg::MODE_CLEAR: begin
          n_members = 0;
          r.ok      = 1'b1;
        end
      endcase
      r.member_count = iois_pkg::COUNT_W'(n_members);
      replies_due.push_back(r);
    endfunction

    function void check_response(logic ok, logic full_refused,
                                 logic [iois_pkg::COUNT_W-1:0] cnt);
      set_reply_t exp;
      if (replies_due.size() == 0) begin
        $error("response word with no request outstanding");
        mismatches++;
        return;
      end
      exp = replies_due.pop_front();
      if (ok !== exp.ok) begin
        $error("ok: expected %0d, got %0d", exp.ok, ok);
        mismatches++;
      end
      if (full_refused !== exp.full_refused) begin
        $error("full_refused: expected %0d, got %0d", exp.full_refused, full_refused);
        mismatches++;
      end
      if (cnt !== exp.member_count) begin
        $error("member_count: expected %0d, got %0d", exp.member_count, cnt);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  iois_req_if req_if ();
  iois_rsp_if rsp_if ();

  insertion_ordered_int_set_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  int_set_tracker tracker = new();

  bit src_gaps    = 1'b0;
  bit sink_stalls = 1'b0;
  int stall_left  = 0;

  always #6 clk = ~clk;

  // Response side: while stalls are enabled, ready drops at random times for a random stretch.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Every response word taken is checked against the oldest reply due.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      tracker.check_response(rsp_if.ok, rsp_if.full_refused, rsp_if.member_count);
    end
  end

  // Offer one request word, perhaps after a short gap, and hold it until it is taken.
  task automatic send_request(input logic [iois_pkg::MODE_W-1:0] mode,
                              input logic [iois_pkg::VALUE_W-1:0] value);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.mode  <= mode;
    req_if.value <= value;
    do @(posedge clk); while (!req_if.ready);
    tracker.note_request(mode, value);
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Random traffic drawn mostly from a small pool of values, so that adds, removes and
  // lookups hit one another and the set often fills; some pool values differ by one bit.
  task automatic run_phase(input int n_items, input int pool_size);
    logic [iois_pkg::VALUE_W-1:0] pool [32];
    logic [iois_pkg::MODE_W-1:0]  mode;
    logic [iois_pkg::VALUE_W-1:0] value;
    int                           pick;
    for (int i = 0; i < pool_size; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0) begin
        pool[i] = pool[i - 1] ^ (32'h1 << $urandom_range(0, 31));
      end else begin
        pool[i] = $urandom;
      end
    end
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 42)      mode = iois_pkg::MODE_ADD;
      else if (pick < 67) mode = iois_pkg::MODE_REMOVE;
      else if (pick < 97) mode = iois_pkg::MODE_CONTAINS;
      else                mode = iois_pkg::MODE_CLEAR;
      if ($urandom_range(0, 9) == 0) value = $urandom;
      else value = pool[$urandom_range(0, pool_size - 1)];
      send_request(mode, value);
    end
  endtask

  // Deadline for a run that has stalled.
  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    req_if.valid <= 1'b0;
    req_if.mode  <= iois_pkg::MODE_ADD;
    req_if.value <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty set, extreme values, duplicates, removal at head and middle.
    send_request(iois_pkg::MODE_CONTAINS, 32'd5);
    send_request(iois_pkg::MODE_REMOVE, 32'd5);
    send_request(iois_pkg::MODE_ADD, WORD_MIN);
    send_request(iois_pkg::MODE_ADD, WORD_MAX);
    send_request(iois_pkg::MODE_ADD, '0);
    send_request(iois_pkg::MODE_ADD, WORD_ALL);
    send_request(iois_pkg::MODE_ADD, WORD_MIN);
    send_request(iois_pkg::MODE_REMOVE, '0);
    send_request(iois_pkg::MODE_REMOVE, WORD_MIN);
    send_request(iois_pkg::MODE_CONTAINS, WORD_ALL);
    send_request(iois_pkg::MODE_REMOVE, 32'd1234);
    // Fill the set, then try an absent and a present value while it is full.
    for (int i = 0; tracker.n_members < SET_CAP; i++) begin
      send_request(iois_pkg::MODE_ADD, 32'h100 + i);
    end
    send_request(iois_pkg::MODE_ADD, 32'd99);
    send_request(iois_pkg::MODE_ADD, WORD_MAX);
    send_request(iois_pkg::MODE_REMOVE, WORD_ALL);
    send_request(iois_pkg::MODE_CLEAR, $urandom);
    // Stale words left behind by the clear must not match.
    send_request(iois_pkg::MODE_CONTAINS, WORD_MAX);

    // Hold the sender until every reply has come back.
    req_if.valid <= 1'b0;
    wait_drained();

    src_gaps = 1'b1; sink_stalls = 1'b1;
    run_phase(270, 4);
    src_gaps = 1'b1; sink_stalls = 1'b0;
    run_phase(270, 12);
    req_if.valid <= 1'b0;
    wait_drained();
    src_gaps = 1'b0; sink_stalls = 1'b1;
    run_phase(270, 20);
    src_gaps = 1'b1; sink_stalls = 1'b1;
    run_phase(270, 32);
    run_phase(270, 18);
    // Last stretch at full rate on both sides.
    src_gaps = 1'b0; sink_stalls = 1'b0;
    run_phase(270, 24);

    req_if.valid <= 1'b0;
    wait_drained();
    repeat (5) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
